FILE: design/rfpa_pkg.sv
// Shared types and constants for the RF power peak/average block.
package rfpa_pkg;

	// Field widths
	localparam int SAMPLE_W   = 12;
	localparam int WLEN_W     = 16;
	localparam int GAIN_W     = 12;
	localparam int OFFS_W     = 12;
	localparam int SUM_W      = 15;
	localparam int WCNT_W     = 3;
	localparam int FPOW_W     = 28;
	localparam int RPOW_W     = 26;
	localparam int Q_W        = 31;
	localparam int PROD_W     = 43;
	localparam int NUM_W      = 44;
	localparam int DEN_W      = 17;
	localparam int RECIP_W    = 28;
	localparam int RCP_IN_W   = 32;
	localparam int RCP_PROD_W = 60;
	localparam int EST_W      = 28;
	localparam int REM_W      = 18;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 4;

	// Register reset values
	localparam logic [WLEN_W-1:0] WLEN_RESET = 16'd2000;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 12'd1000;
	localparam logic [OFFS_W-1:0] OFFS_RESET = 12'd54;

	// Calibration quadratic, scaled by 10000: 117*d*d + 4095*d + 309670
	localparam logic [GAIN_W-1:0] Q_C2 = 12'd117;
	localparam logic [Q_W-1:0]    Q_C0 = 31'd309670;

	// 256/10000 = 16/625 on Q; forward adds gain/1000 -> 2/78125 on Q*gain
	localparam logic [DEN_W-1:0]   DEN_REFL   = 17'd625;
	localparam logic [DEN_W-1:0]   DEN_FWD    = 17'd78125;
	// floor(2^35/625) and floor(2^44/78125), used with a 32-bit right shift
	localparam logic [RECIP_W-1:0] RECIP_REFL = 28'd54975581;
	localparam logic [RECIP_W-1:0] RECIP_FWD  = 28'd225179981;

	// Register map (index = paddr[3:2])
	typedef enum logic [1:0] {
		REG_WINDOW_LENGTH    = 2'd0,
		REG_FORWARD_GAIN     = 2'd1,
		REG_FORWARD_OFFSET   = 2'd2,
		REG_REFLECTED_OFFSET = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [WLEN_W-1:0] window_length;
		logic [GAIN_W-1:0] forward_gain;
		logic [OFFS_W-1:0] forward_offset;
		logic [OFFS_W-1:0] reflected_offset;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AVG,
		ST_DIFF,
		ST_SQ,
		ST_K,
		ST_Q,
		ST_GAIN,
		ST_RECIP,
		ST_REM,
		ST_STORE,
		ST_OUT
	} state_t;

	// Controller -> datapath
	typedef struct packed {
		logic sample;
		logic avg;
		logic diff;
		logic sq;
		logic k;
		logic q;
		logic gain;
		logic recip;
		logic rem;
		logic store;
		logic out_load;
		logic sel_fwd;
	} cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic group_end;
		logic out_free;
	} status_t;

endpackage

FILE: design/rfpa_if.sv
// Sample and result channel interfaces.
interface rfpa_sample_if import rfpa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] forward_sample;
	logic [SAMPLE_W-1:0] reflected_sample;

	modport source (output valid, output forward_sample, output reflected_sample,
		input ready);
	modport sink (input valid, input forward_sample, input reflected_sample,
		output ready);
endinterface

interface rfpa_result_if import rfpa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FPOW_W-1:0]   forward_power;
	logic [RPOW_W-1:0]   reflected_power;
	logic [SAMPLE_W-1:0] forward_average;
	logic [SAMPLE_W-1:0] reflected_average;

	modport source (output valid, output forward_power, output reflected_power,
		output forward_average, output reflected_average, input ready);
	modport sink (input valid, input forward_power, input reflected_power,
		input forward_average, input reflected_average, output ready);
endinterface

FILE: design/rf_power_peak_average.sv
// Top level of the RF power peak/average detector.
//
//  channel   dir  handshake             payload
//  samples   in   valid/ready           forward_sample, reflected_sample
//  results   out  valid/ready           forward_power, reflected_power, *_average
//  apb       in   psel/penable/pready   paddr[3:2] selects register, pwdata
//
// Peaks, counters and sums update at once on each sample beat.
// At the end of each group of windows the calibration sequence holds samples off
// (plus any wait for the result slot): average, offset, then a reflected pass and
// a forward pass (quadratic, gain, reciprocal divide in three steps), then the
// result load.
// Reset clears counters, peaks, sums and the result valid; registers take defaults.
// A result waiting in the output register does not stop sample beats.
module rf_power_peak_average import rfpa_pkg::*; #(
	parameter int WINDOWS_PER_RESULT = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rfpa_sample_if.sink           samples,
	rfpa_result_if.source         results,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t stat;
	logic    in_ready;

	assign samples.ready = in_ready;

	rfpa_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rfpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rfpa_dp #(
		.WINDOWS_PER_RESULT (WINDOWS_PER_RESULT)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.cmd               (cmd),
		.stat              (stat),
		.forward_sample    (samples.forward_sample),
		.reflected_sample  (samples.reflected_sample),
		.out_valid         (results.valid),
		.out_ready         (results.ready),
		.forward_power     (results.forward_power),
		.reflected_power   (results.reflected_power),
		.forward_average   (results.forward_average),
		.reflected_average (results.reflected_average)
	);

endmodule

FILE: design/rfpa_cfg.sv
// APB register file holding window length, forward gain and the two offsets.
module rfpa_cfg import rfpa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     regs_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = regs_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.window_length    <= WLEN_RESET;
			regs_q.forward_gain     <= GAIN_RESET;
			regs_q.forward_offset   <= OFFS_RESET;
			regs_q.reflected_offset <= OFFS_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_WINDOW_LENGTH:    regs_q.window_length    <= pwdata[WLEN_W-1:0];
				REG_FORWARD_GAIN:     regs_q.forward_gain     <= pwdata[GAIN_W-1:0];
				REG_FORWARD_OFFSET:   regs_q.forward_offset   <= pwdata[OFFS_W-1:0];
				REG_REFLECTED_OFFSET: regs_q.reflected_offset <= pwdata[OFFS_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (idx)
			REG_WINDOW_LENGTH:    prdata = APB_DATA_W'(regs_q.window_length);
			REG_FORWARD_GAIN:     prdata = APB_DATA_W'(regs_q.forward_gain);
			REG_FORWARD_OFFSET:   prdata = APB_DATA_W'(regs_q.forward_offset);
			REG_REFLECTED_OFFSET: prdata = APB_DATA_W'(regs_q.reflected_offset);
			default:              prdata = '0;
		endcase
	end

endmodule

FILE: design/rfpa_dp.sv
// Datapath: peak tracking, window sums, averaging, shared multiplier, reciprocal division.
module rfpa_dp import rfpa_pkg::*; #(
	parameter int WINDOWS_PER_RESULT = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  cmd_t                cmd,
	output status_t             stat,
	input  logic [SAMPLE_W-1:0] forward_sample,
	input  logic [SAMPLE_W-1:0] reflected_sample,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [FPOW_W-1:0]   forward_power,
	output logic [RPOW_W-1:0]   reflected_power,
	output logic [SAMPLE_W-1:0] forward_average,
	output logic [SAMPLE_W-1:0] reflected_average
);

	// Sum / W as multiply by reciprocal: exact for 15-bit sums and W up to 8
	localparam int AVG_SHIFT  = SUM_W + 3;
	localparam int AVG_MULT_W = AVG_SHIFT + 1;
	localparam int AVG_PROD_W = SUM_W + AVG_MULT_W;
	localparam logic [AVG_MULT_W-1:0] AVG_MULT =
		AVG_MULT_W'(((1 << AVG_SHIFT) + WINDOWS_PER_RESULT - 1) / WINDOWS_PER_RESULT);
	localparam logic [WCNT_W:0] WPR = (WCNT_W+1)'(WINDOWS_PER_RESULT);

	// Sample-side state
	logic [WLEN_W-1:0]   scount_q;
	logic [WCNT_W-1:0]   wcount_q;
	logic [SAMPLE_W-1:0] fpeak_q, rpeak_q;
	logic [SUM_W-1:0]    fsum_q, rsum_q;

	// Calibration state
	logic [SAMPLE_W-1:0] favg_q, ravg_q, df_q, dr_q;
	logic [PROD_W-1:0]   prod_q;
	logic [Q_W-1:0]      q_q;
	logic [NUM_W-1:0]    num_q;
	logic [EST_W-1:0]    est_q;
	logic [REM_W-1:0]    rem_q;
	logic [FPOW_W-1:0]   fpow_q;
	logic [RPOW_W-1:0]   rpow_q;
	logic                out_valid_q;

	logic [SAMPLE_W-1:0]   fpeak_nxt, rpeak_nxt, d_sel;
	logic [WLEN_W-1:0]     cnt_inc;
	logic                  win_end, last_win;
	logic [AVG_PROD_W-1:0] favg_prod, ravg_prod;
	logic [Q_W-1:0]        mul_a;
	logic [GAIN_W-1:0]     mul_b;
	logic [DEN_W-1:0]      den_sel;
	logic [RECIP_W-1:0]    recip_sel;
	logic [NUM_W-1:0]      num_nxt;
	logic [RCP_IN_W-1:0]   rcp_in;
	logic [RCP_PROD_W-1:0] rcp_prod;
	logic [NUM_W-1:0]      back_prod, rem_full;
	logic [EST_W-1:0]      quo;

	// Peak and window counting
	assign fpeak_nxt = (forward_sample > fpeak_q) ? forward_sample : fpeak_q;
	assign rpeak_nxt = (reflected_sample > rpeak_q) ? reflected_sample : rpeak_q;
	assign cnt_inc   = scount_q + 1'b1;
	assign win_end   = (cnt_inc == cfg.window_length);
	assign last_win  = (({1'b0, wcount_q} + 1'b1) >= WPR);

	assign stat.group_end = win_end && last_win;
	assign stat.out_free  = !out_valid_q || out_ready;

	assign favg_prod = AVG_PROD_W'(fsum_q) * AVG_PROD_W'(AVG_MULT);
	assign ravg_prod = AVG_PROD_W'(rsum_q) * AVG_PROD_W'(AVG_MULT);

	// Shared multiplier operand select
	assign d_sel = cmd.sel_fwd ? df_q : dr_q;
	always_comb begin
		mul_a = {{(Q_W-SAMPLE_W){1'b0}}, d_sel};
		mul_b = d_sel;
		if (cmd.k) begin
			mul_a = prod_q[Q_W-1:0];
			mul_b = Q_C2;
		end else if (cmd.gain) begin
			mul_a = q_q;
			mul_b = cfg.forward_gain;
		end
	end

	// Division by a constant: forward 2*P/78125, reflected 16*Q/625.
	// Estimate from the top 32 bits of the dividend times the reciprocal,
	// then back-multiply; the estimate is low by at most one.
	assign den_sel   = cmd.sel_fwd ? DEN_FWD : DEN_REFL;
	assign recip_sel = cmd.sel_fwd ? RECIP_FWD : RECIP_REFL;
	assign num_nxt   = cmd.sel_fwd ? {prod_q, 1'b0} : NUM_W'({q_q, 4'b0});
	assign rcp_in    = cmd.sel_fwd ? prod_q[PROD_W-1 -: RCP_IN_W] : {q_q, 1'b0};
	assign rcp_prod  = RCP_PROD_W'(rcp_in) * RCP_PROD_W'(recip_sel);
	assign back_prod = NUM_W'(est_q) * NUM_W'(den_sel);
	assign rem_full  = num_q - back_prod;
	assign quo       = est_q + EST_W'(rem_q >= REM_W'(den_sel));

	// Control registers of the sample side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scount_q <= '0;
			wcount_q <= '0;
			fpeak_q  <= '0;
			rpeak_q  <= '0;
			fsum_q   <= '0;
			rsum_q   <= '0;
		end else if (cmd.sample) begin
			fpeak_q  <= fpeak_nxt;
			rpeak_q  <= rpeak_nxt;
			scount_q <= win_end ? '0 : cnt_inc;
			if (win_end) begin
				fsum_q <= fsum_q + SUM_W'(fpeak_nxt);
				rsum_q <= rsum_q + SUM_W'(rpeak_nxt);
				if (!last_win)
					wcount_q <= wcount_q + 1'b1;
			end
		end else if (cmd.diff) begin
			wcount_q <= '0;
			fpeak_q  <= '0;
			rpeak_q  <= '0;
			fsum_q   <= '0;
			rsum_q   <= '0;
		end
	end

	// Averages, offsets, quadratic and division
	always_ff @(posedge clk) begin
		if (cmd.avg) begin
			favg_q <= favg_prod[AVG_SHIFT +: SAMPLE_W];
			ravg_q <= ravg_prod[AVG_SHIFT +: SAMPLE_W];
		end
		if (cmd.diff) begin
			df_q <= (favg_q > cfg.forward_offset) ? favg_q - cfg.forward_offset : '0;
			dr_q <= (ravg_q > cfg.reflected_offset) ? ravg_q - cfg.reflected_offset : '0;
		end
		if (cmd.sq || cmd.k || cmd.gain)
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		if (cmd.q)
			q_q <= prod_q[Q_W-1:0]
				+ ({{(Q_W-SAMPLE_W-12){1'b0}}, d_sel, 12'b0} - Q_W'(d_sel))
				+ Q_C0;
		if (cmd.recip) begin
			num_q <= num_nxt;
			est_q <= rcp_prod[RCP_PROD_W-1 -: EST_W];
		end
		if (cmd.rem)
			rem_q <= rem_full[REM_W-1:0];
		if (cmd.store) begin
			if (cmd.sel_fwd)
				fpow_q <= (df_q == '0) ? '0 : quo;
			else
				rpow_q <= quo[RPOW_W-1:0];
		end
		if (cmd.out_load) begin
			forward_power     <= fpow_q;
			reflected_power   <= rpow_q;
			forward_average   <= favg_q;
			reflected_average <= ravg_q;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;

	// Window counter stays below the group size
	a_wcount_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, wcount_q} < WPR)) else $error("window count out of range");

	// Quotient estimate is short by at most one divisor
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> (rem_q < {den_sel, 1'b0})) else $error("division remainder out of range");

	// Forward power is zero whenever the forward excess is zero
	a_fwd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.store && cmd.sel_fwd && df_q == '0) |=> (fpow_q == '0))
		else $error("forward power not forced to zero");

endmodule

FILE: design/rfpa_ctrl.sv
// Controller: sequences sample beats and the per-group calibration steps.
module rfpa_ctrl import rfpa_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t stat,
	output cmd_t    cmd
);

	state_t state_q, state_nxt;
	logic   fwd_q;
	logic   beat;

	assign beat = in_valid && in_ready;

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (beat && stat.group_end) state_nxt = ST_AVG;
			ST_AVG:   state_nxt = ST_DIFF;
			ST_DIFF:  state_nxt = ST_SQ;
			ST_SQ:    state_nxt = ST_K;
			ST_K:     state_nxt = ST_Q;
			ST_Q:     state_nxt = fwd_q ? ST_GAIN : ST_RECIP;
			ST_GAIN:  state_nxt = ST_RECIP;
			ST_RECIP: state_nxt = ST_REM;
			ST_REM:   state_nxt = ST_STORE;
			ST_STORE: state_nxt = fwd_q ? ST_OUT : ST_SQ;
			ST_OUT:   if (stat.out_free) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd          = '0;
		in_ready     = 1'b0;
		cmd.sel_fwd  = fwd_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.sample = beat;
			end
			ST_AVG:   cmd.avg      = 1'b1;
			ST_DIFF:  cmd.diff     = 1'b1;
			ST_SQ:    cmd.sq       = 1'b1;
			ST_K:     cmd.k        = 1'b1;
			ST_Q:     cmd.q        = 1'b1;
			ST_GAIN:  cmd.gain     = 1'b1;
			ST_RECIP: cmd.recip    = 1'b1;
			ST_REM:   cmd.rem      = 1'b1;
			ST_STORE: cmd.store    = 1'b1;
			ST_OUT:   cmd.out_load = stat.out_free;
			default: ;
		endcase
	end

	// State and path select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fwd_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_AVG)
				fwd_q <= 1'b0;
			else if (state_q == ST_STORE)
				fwd_q <= 1'b1;
		end
	end

	// Result register is loaded only into a free slot
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free) else $error("result overwritten");

	// Gain step only on the forward pass
	a_gain_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GAIN) |-> fwd_q) else $error("gain step on reflected pass");

	// Samples are held off while a group is being calibrated; checked at the offset step
	a_no_beat_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_AVG) |=> !cmd.sample) else $error("sample taken while busy");

endmodule

FILE: tb/rfpa_power_check.sv
`timescale 1ns / 100ps
// Checker for the RF power block: watches sample, result and register beats, predicts, compares.
module rfpa_power_check import rfpa_pkg::*; #(
	parameter int WINDOWS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rfpa_sample_if                samples,
	rfpa_result_if                results,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output int                    mismatches,
	output int                    outstanding
);

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [FPOW_W-1:0]   fwd_power;
		logic [RPOW_W-1:0]   refl_power;
		logic [SAMPLE_W-1:0] fwd_avg;
		logic [SAMPLE_W-1:0] refl_avg;
	} power_result_t;

	// Shadow registers and detector state
	cfg_t                cfg;
	logic [WLEN_W-1:0]   sample_count;
	logic [WCNT_W-1:0]   window_count;
	logic [SAMPLE_W-1:0] fwd_peak;
	logic [SAMPLE_W-1:0] refl_peak;
	logic [SUM_W-1:0]    fwd_sum;
	logic [SUM_W-1:0]    refl_sum;
	power_result_t       expected_powers[$];

	// Calibration quadratic scaled by 10000, exact
	function automatic longint unsigned cal_quad(input longint unsigned d);
		return 117 * d * d + 4095 * d + 309670;
	endfunction

	// Average minus offset, floored at zero
	function automatic longint unsigned floor_diff(input logic [SAMPLE_W-1:0] avg,
			input logic [OFFS_W-1:0] offs);
		return (avg > offs) ? longint'(avg - offs) : 0;
	endfunction

	// One sample beat: peak hold, window and group counting, calibration at group end
	task automatic take_sample(input logic [SAMPLE_W-1:0] fs, input logic [SAMPLE_W-1:0] rs);
		power_result_t   r;
		longint unsigned df;
		longint unsigned dr;
		if (fs > fwd_peak) fwd_peak = fs;
		if (rs > refl_peak) refl_peak = rs;
		sample_count = sample_count + 1'b1;
		if (sample_count != cfg.window_length) return;
		sample_count = '0;
		fwd_sum = fwd_sum + fwd_peak;
		refl_sum = refl_sum + refl_peak;
		// peaks carry over into the next window of the same group
		if (int'(window_count) + 1 < WINDOWS) begin
			window_count = window_count + 1'b1;
			return;
		end
		r.fwd_avg = SAMPLE_W'(fwd_sum / WINDOWS);
		r.refl_avg = SAMPLE_W'(refl_sum / WINDOWS);
		df = floor_diff(r.fwd_avg, cfg.forward_offset);
		dr = floor_diff(r.refl_avg, cfg.reflected_offset);
		r.refl_power = RPOW_W'(cal_quad(dr) * 256 / 10000);
		// forward power is forced to zero when its offset-corrected value is zero
		if (df == 0)
			r.fwd_power = '0;
		else
			r.fwd_power = FPOW_W'(cal_quad(df) * 256 * cfg.forward_gain / 10000000);
		expected_powers.push_back(r);
		outstanding++;
		fwd_peak = '0;
		refl_peak = '0;
		fwd_sum = '0;
		refl_sum = '0;
		window_count = '0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		power_result_t got;
		power_result_t want;
		if (!arst_n) begin
			cfg = '{window_length: WLEN_RESET, forward_gain: GAIN_RESET,
				forward_offset: OFFS_RESET, reflected_offset: OFFS_RESET};
			sample_count = '0;
			window_count = '0;
			fwd_peak = '0;
			refl_peak = '0;
			fwd_sum = '0;
			refl_sum = '0;
			expected_powers.delete();
			outstanding = 0;
			mismatches = 0;
		end else begin
			// Result beat against the oldest expectation
			if (results.valid && results.ready) begin
				got = '{results.forward_power, results.reflected_power,
					results.forward_average, results.reflected_average};
				if (expected_powers.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: unexpected result beat: fwd_power %0d refl_power %0d fwd_avg %0d refl_avg %0d",
							$time, got.fwd_power, got.refl_power, got.fwd_avg, got.refl_avg);
				end else begin
					want = expected_powers.pop_front();
					outstanding--;
					if (got.fwd_power !== want.fwd_power || got.refl_power !== want.refl_power ||
							got.fwd_avg !== want.fwd_avg || got.refl_avg !== want.refl_avg) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display({"%0t: result mismatch: fwd_power exp %0d got %0d, ",
								"refl_power exp %0d got %0d, fwd_avg exp %0d got %0d, ",
								"refl_avg exp %0d got %0d"}, $time,
								want.fwd_power, got.fwd_power, want.refl_power, got.refl_power,
								want.fwd_avg, got.fwd_avg, want.refl_avg, got.refl_avg);
					end
				end
			end

			// Sample beat
			if (samples.valid && samples.ready)
				take_sample(samples.forward_sample, samples.reflected_sample);

			// Register write, value masked to the register width
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_WINDOW_LENGTH:    cfg.window_length = pwdata[WLEN_W-1:0];
					REG_FORWARD_GAIN:     cfg.forward_gain = pwdata[GAIN_W-1:0];
					REG_FORWARD_OFFSET:   cfg.forward_offset = pwdata[OFFS_W-1:0];
					REG_REFLECTED_OFFSET: cfg.reflected_offset = pwdata[OFFS_W-1:0];
					default: ;
				endcase
			end
		end
	end

endmodule

FILE: tb/tb_rf_power_peak_average.sv
`timescale 1ns / 100ps
// Testbench top for the RF power peak/average block: clock, reset, stimulus and verdict.
module tb_rf_power_peak_average;
	import rfpa_pkg::*;

	localparam int GROUP_WINDOWS = 8;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 150;
	localparam int RANDOM_ITEMS  = 360;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic                  pready;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  no_idle;
	int                    mismatches;
	int                    outstanding;
	int                    items_sent;
	int                    cur_wl;

	rfpa_sample_if smp();
	rfpa_result_if res();

	rf_power_peak_average #(.WINDOWS_PER_RESULT(GROUP_WINDOWS)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (smp),
		.results (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	rfpa_power_check #(.WINDOWS(GROUP_WINDOWS)) power_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.samples     (smp),
		.results     (res),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Result side stalls about 23% of cycles unless in a no-idle stretch
	always @(posedge clk) begin
		res.ready <= no_idle || ($urandom_range(99) >= 23);
	end

	// Watchdog: ends the run when no beat of any kind is seen for too long
	initial begin
		int stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (smp.valid && smp.ready) || (res.valid && res.ready) ||
					(psel && penable && pready))
				stalled = 0;
			else
				stalled++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// Register write: setup cycle, then access until pready
	task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// One sample beat, with random gaps ahead of it
	task automatic send_sample(input logic [SAMPLE_W-1:0] fwd, input logic [SAMPLE_W-1:0] refl);
		while (!no_idle && $urandom_range(99) < 23) begin
			smp.valid <= 1'b0;
			@(posedge clk);
		end
		smp.valid <= 1'b1;
		smp.forward_sample <= fwd;
		smp.reflected_sample <= refl;
		do @(posedge clk); while (!smp.ready);
		items_sent++;
	endtask

	task automatic send_random(input int n, input int fwd_amp, input int refl_amp);
		for (int i = 0; i < n; i++)
			send_sample($urandom_range(0, fwd_amp), $urandom_range(0, refl_amp));
	endtask

	// Drop valid, wait for every expected result, then let the block go quiet
	task automatic settle();
		smp.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Offsets: extremes, anything, or close to the sample level so d often hits zero
	function automatic int pick_offset(input int amp);
		case ($urandom_range(3))
			0: return 0;
			1: return 4095;
			2: return $urandom_range(0, 4095);
			default: return $urandom_range(amp / 2, amp);
		endcase
	endfunction

	initial begin
		logic [APB_DATA_W-1:0] word;
		int phase;
		int fwd_amp;
		int refl_amp;
		int ngroups;
		int start_items;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		smp.valid = 1'b0;
		smp.forward_sample = '0;
		smp.reflected_sample = '0;
		no_idle = 1'b0;
		items_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: one-sample windows, gain and offsets at their defaults first
		cur_wl = 1;
		write_reg(REG_WINDOW_LENGTH, 32'd1);
		// full-scale samples: largest averages and powers
		repeat (GROUP_WINDOWS) send_sample('1, '1);
		settle();
		// zero samples: below offset, forward forced to zero, reflected constant term
		repeat (GROUP_WINDOWS) send_sample('0, '0);
		settle();
		// max gain, forward offset zero, reflected offset equal to its average;
		// upper data bits set to check masking
		write_reg(REG_FORWARD_GAIN, 32'hFFFF_FFFF);
		write_reg(REG_FORWARD_OFFSET, 32'hABCD_E000);
		write_reg(REG_REFLECTED_OFFSET, 32'h5A5A_5000 | 32'd100);
		// forward peak held across windows; equal samples do not replace it
		send_sample(12'h555, 12'd100);
		send_sample(12'h400, 12'd100);
		send_sample(12'hAAA, 12'd100);
		send_sample(12'hAAA, 12'd100);
		send_sample(12'h800, 12'd100);
		send_sample(12'h001, 12'd100);
		send_sample(12'hAA9, 12'd100);
		send_sample(12'hAAB, 12'd100);
		settle();

		// Random phases of whole groups under changing register settings
		phase = 0;
		start_items = items_sent;
		while (items_sent - start_items < RANDOM_ITEMS) begin
			no_idle <= (phase >= 4 && phase < 8);
			fwd_amp = ($urandom_range(3) == 0) ? 4095 : $urandom_range(0, 4095);
			refl_amp = ($urandom_range(3) == 0) ? 4095 : $urandom_range(0, 4095);
			if (phase == 0 || $urandom_range(1)) begin
				cur_wl = ($urandom_range(7) == 0) ? $urandom_range(3, 10) : $urandom_range(1, 2);
				word = $urandom();
				word[WLEN_W-1:0] = cur_wl[WLEN_W-1:0];
				write_reg(REG_WINDOW_LENGTH, word);
			end
			if (phase == 0 || $urandom_range(1)) begin
				word = $urandom();
				case ($urandom_range(3))
					0: word[GAIN_W-1:0] = '0;
					1: word[GAIN_W-1:0] = '1;
					default: ;
				endcase
				write_reg(REG_FORWARD_GAIN, word);
			end
			if (phase == 0 || $urandom_range(1)) begin
				word = $urandom();
				word[OFFS_W-1:0] = OFFS_W'(pick_offset(fwd_amp));
				write_reg(REG_FORWARD_OFFSET, word);
			end
			if (phase == 0 || $urandom_range(1)) begin
				word = $urandom();
				word[OFFS_W-1:0] = OFFS_W'(pick_offset(refl_amp));
				write_reg(REG_REFLECTED_OFFSET, word);
			end
			ngroups = $urandom_range(1, 3);
			send_random(ngroups * GROUP_WINDOWS * cur_wl, fwd_amp, refl_amp);
			settle();
			phase++;
		end

		if (mismatches == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: rf_power_peak_average.f
design/rfpa_pkg.sv
design/rfpa_if.sv
design/rfpa_cfg.sv
design/rfpa_dp.sv
design/rfpa_ctrl.sv
design/rf_power_peak_average.sv
tb/rfpa_power_check.sv
tb/tb_rf_power_peak_average.sv
